[src/lgr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lgr_pkg;

  localparam int unsigned ROW_W       = 64;
  localparam int unsigned CFG_W       = 7;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd40;
  localparam logic [CFG_W-1:0] WIDTH_MIN   = 7'd3;

  // B3/S23 rule
  localparam logic [3:0] BORN_COUNT = 4'd3;
  localparam logic [3:0] KEEP_LOW   = 4'd2;
  localparam logic [3:0] KEEP_HIGH  = 4'd3;

  // output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic             done;
  } out_entry_t;

  // control handed to the merge stage
  typedef struct packed {
    logic             gen_en;  // 0: pass the middle row through
    logic [CFG_W-1:0] width;   // effective (clamped) grid width
  } merge_ctrl_t;

endpackage

`default_nettype wire

[src/lgr_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

// One cell of the rule: eight neighbor bits plus the cell itself.
module lgr_lane (
  input  logic [7:0] nbr_i,
  input  logic       alive_i,
  output logic       next_o
);
  import lgr_pkg::*;

  logic [3:0] count;

  always_comb begin
    count = 4'd0;
    for (int k = 0; k < 8; k++) begin
      count = count + 4'(nbr_i[k]);
    end
  end

  assign next_o = alive_i ? ((count >= KEEP_LOW) && (count <= KEEP_HIGH))
                          : (count == BORN_COUNT);

endmodule

`default_nettype wire

[src/lgr_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

// Merges lanes into a row: with gen_en the interior columns come from
// the lanes, others from the middle row; columns past width cleared.
module lgr_merge #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic [MAX_WIDTH-1:0] lane_next_i,
  input  logic [MAX_WIDTH-1:0] mid_i,
  input  lgr_pkg::merge_ctrl_t ctrl_i,
  output logic [MAX_WIDTH-1:0] row_o
);
  import lgr_pkg::*;

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      if (CFG_W'(i) >= ctrl_i.width) begin
        row_o[i] = 1'b0;
      end else if (ctrl_i.gen_en && (i >= 1) && (CFG_W'(i + 1) < ctrl_i.width)) begin
        row_o[i] = lane_next_i[i];
      end else begin
        row_o[i] = mid_i[i];
      end
    end
  end

endmodule

`default_nettype wire

[src/life_generation_row_stream.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   row_cells_i, first_row_i, last_row_i
// out       out  out_valid_o / out_ready_i next_row_cells_o, grid_done_o
// cfg       in   cfg_we_i (no wait)        cfg_wdata_i (grid_width)
//
// One row per cycle while in_ready_o is high: every column has its own rule
// lane, so a row is finished in the cycle it is accepted and enters a 4-entry
// output queue. A lone last row yields one transaction, any other last row two.
// in_ready_o is high while the queue holds two entries or fewer.
// Reset (rst_ni low, async) clears the queue, the row count and grid_width=40.
// Results appear on out, at the earliest, in the cycle after their row.
module life_generation_row_stream #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lgr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [lgr_pkg::ROW_W-1:0] row_cells_i,
  input  logic                     first_row_i,
  input  logic                     last_row_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [lgr_pkg::ROW_W-1:0] next_row_cells_o,
  output logic                     grid_done_o
);
  import lgr_pkg::*;

  typedef enum logic [1:0] {
    ROWS_NONE,
    ROWS_ONE,
    ROWS_TWO
  } rows_e;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      width_cfg_q <= cfg_wdata_i;
    end
  end

  // clamp to [3, MAX_WIDTH]
  logic [CFG_W-1:0] eff_width;
  always_comb begin
    eff_width = width_cfg_q;
    if (eff_width < WIDTH_MIN) eff_width = WIDTH_MIN;
    if (eff_width > CFG_W'(MAX_WIDTH)) eff_width = CFG_W'(MAX_WIDTH);
  end

  logic [MAX_WIDTH-1:0] col_mask;
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      col_mask[i] = CFG_W'(i) < eff_width;
    end
  end

  // ---------------------------------------------------------------------------
  // row window
  // ---------------------------------------------------------------------------
  rows_e                rows_q, rows_d;
  logic [MAX_WIDTH-1:0] older_q, older_d;
  logic [MAX_WIDTH-1:0] newer_q, newer_d;

  logic [MAX_WIDTH-1:0] above, mid, below;
  assign above = older_q & col_mask;
  assign mid   = newer_q & col_mask;
  assign below = row_cells_i[MAX_WIDTH-1:0] & col_mask;

  // zero padding on both sides so every lane sees three columns
  logic [MAX_WIDTH+1:0] above_p, mid_p, below_p;
  assign above_p = {1'b0, above, 1'b0};
  assign mid_p   = {1'b0, mid,   1'b0};
  assign below_p = {1'b0, below, 1'b0};

  logic [MAX_WIDTH-1:0] lane_next;

  for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_lane
    lgr_lane u_lane (
      .nbr_i   ({above_p[g+2:g], mid_p[g+2], mid_p[g], below_p[g+2:g]}),
      .alive_i (mid[g]),
      .next_o  (lane_next[g])
    );
  end

  rows_e       rows_eff;
  merge_ctrl_t merge_ctrl;
  logic [MAX_WIDTH-1:0] merged;

  assign rows_eff          = first_row_i ? ROWS_NONE : rows_q;
  assign merge_ctrl.gen_en = (rows_eff == ROWS_TWO);
  assign merge_ctrl.width  = eff_width;

  lgr_merge #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_merge (
    .lane_next_i (lane_next),
    .mid_i       (mid),
    .ctrl_i      (merge_ctrl),
    .row_o       (merged)
  );

  // ---------------------------------------------------------------------------
  // per-row transaction: window update and queue pushes
  // ---------------------------------------------------------------------------
  logic       in_fire;
  logic [1:0] push_cnt;
  out_entry_t push0, push1;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    rows_d   = rows_q;
    older_d  = older_q;
    newer_d  = newer_q;
    push_cnt = 2'd0;
    push0    = '{cells: ROW_W'(merged), done: 1'b0};
    push1    = '{cells: ROW_W'(below),  done: 1'b1};
    if (in_fire) begin
      if (rows_eff == ROWS_NONE) begin
        // start of a grid; a lone row that is also last goes straight out
        older_d = '0;
        newer_d = below;
        if (last_row_i) begin
          push0    = '{cells: ROW_W'(below), done: 1'b1};
          push_cnt = 2'd1;
          rows_d   = ROWS_NONE;
        end else begin
          rows_d = ROWS_ONE;
        end
      end else begin
        // with one row held, merge passes it through as the top border
        older_d  = newer_q;
        newer_d  = below;
        push_cnt = 2'd1;
        rows_d   = ROWS_TWO;
        if (last_row_i) begin
          push_cnt = 2'd2;
          rows_d   = ROWS_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_NONE;
      older_q <= '0;
      newer_q <= '0;
    end else begin
      rows_q  <= rows_d;
      older_q <= older_d;
      newer_q <= newer_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------------
  out_entry_t       fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q,  count_d;
  logic             out_fire;

  assign out_fire   = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign in_ready_o  = (count_q <= CNT_W'(FIFO_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(out_fire);
  assign count_d  = count_q + CNT_W'(push_cnt) - CNT_W'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      fifo_mem[wr_ptr_q] <= push0;
    end
    if (push_cnt == 2'd2) begin
      fifo_mem[wr_ptr_q + PTR_W'(1)] <= push1;
    end
  end

  out_entry_t head;
  assign head             = fifo_mem[rd_ptr_q];
  assign next_row_cells_o = head.cells;
  assign grid_done_o      = head.done;

endmodule

`default_nettype wire

[src/lgr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lgr_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_o,
  input  logic                      last_row_i,
  input  logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  logic [lgr_pkg::ROW_W-1:0] next_row_cells_o,
  input  logic                      grid_done_o
);
  import lgr_pkg::*;

  // a stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(next_row_cells_o) && $stable(grid_done_o))
    else $error("output payload changed while stalled");

  // input is only held off by pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("in_ready_o low with empty output queue");

  // a last row always produces a result
  a_last_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_row_i |=> out_valid_o)
    else $error("last row produced no output");

endmodule

bind life_generation_row_stream lgr_checker u_lgr_checker (.*);

`default_nettype wire

[bench/life_row_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the width register, predicts the next-generation
// rows and compares every out transaction against the oldest row still due.
module life_row_checker #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lgr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [lgr_pkg::ROW_W-1:0] row_cells_i,
  input  logic                      first_row_i,
  input  logic                      last_row_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [lgr_pkg::ROW_W-1:0] next_row_cells_i,
  input  logic                      grid_done_i,
  output int                        mismatches_o,
  output int                        rows_due_o
);
  import lgr_pkg::*;

  logic [CFG_W-1:0] width_q;
  logic [ROW_W-1:0] older_q;
  logic [ROW_W-1:0] newer_q;
  logic [1:0]       held_q;
  out_entry_t       rows_due[$];
  int               mismatches;

  function automatic int clamp_width(input logic [CFG_W-1:0] w_raw);
    int w;
    w = int'(w_raw);
    if (w < int'(WIDTH_MIN)) w = int'(WIDTH_MIN);
    if (w > int'(MAX_WIDTH)) w = int'(MAX_WIDTH);
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] width_mask(input int w);
    if (w >= int'(ROW_W)) return '1;
    return ~({ROW_W{1'b1}} << w);
  endfunction

  // B3/S23 on the interior columns; border columns keep their old value
  function automatic logic [ROW_W-1:0] evolve_row(input logic [ROW_W-1:0] above,
                                                  input logic [ROW_W-1:0] mid,
                                                  input logic [ROW_W-1:0] below,
                                                  input int w);
    logic [ROW_W-1:0] res;
    int               n;
    logic             alive;
    res = mid;
    for (int i = 1; i + 1 < w; i++) begin
      n = int'(above[i-1]) + int'(above[i]) + int'(above[i+1])
        + int'(mid[i-1]) + int'(mid[i+1])
        + int'(below[i-1]) + int'(below[i]) + int'(below[i+1]);
      alive = mid[i];
      if (alive) res[i] = (n >= int'(KEEP_LOW)) && (n <= int'(KEEP_HIGH));
      else       res[i] = (n == int'(BORN_COUNT));
    end
    return res & width_mask(w);
  endfunction

  task automatic report(input string what, input logic [ROW_W-1:0] got,
                        input logic [ROW_W-1:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // one accepted row: update the row window and queue the rows it releases
  task automatic advance_grid(input logic [ROW_W-1:0] cells, input logic first_mark,
                              input logic last_mark);
    int               w;
    logic [ROW_W-1:0] m;
    logic [ROW_W-1:0] row;
    out_entry_t       entry;
    w   = clamp_width(width_q);
    m   = width_mask(w);
    row = cells & m;
    if (first_mark) held_q = 2'd0;
    if (held_q == 2'd0) begin
      older_q = '0;
      newer_q = row;
      if (last_mark) begin
        entry.cells = row;
        entry.done  = 1'b1;
        rows_due.push_back(entry);
      end else begin
        held_q = 2'd1;
      end
    end else begin
      if (held_q == 2'd1) entry.cells = newer_q & m;
      else entry.cells = evolve_row(older_q & m, newer_q & m, row, w);
      entry.done = 1'b0;
      rows_due.push_back(entry);
      older_q = newer_q;
      newer_q = row;
      held_q  = 2'd2;
      if (last_mark) begin
        entry.cells = row;
        entry.done  = 1'b1;
        rows_due.push_back(entry);
        held_q = 2'd0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_entry_t want;
    if (!rst_ni) begin
      width_q    = WIDTH_RESET;
      older_q    = '0;
      newer_q    = '0;
      held_q     = 2'd0;
      rows_due.delete();
      mismatches = 0;
      mismatches_o <= 0;
      rows_due_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (rows_due.size() == 0) begin
          report("row with none due", next_row_cells_i, '0);
        end else begin
          want = rows_due.pop_front();
          if (next_row_cells_i !== want.cells) begin
            report("next_row_cells", next_row_cells_i, want.cells);
          end
          if (grid_done_i !== want.done) begin
            report("grid_done", ROW_W'(grid_done_i), ROW_W'(want.done));
          end
        end
      end
      // a width write takes effect for rows after this edge
      if (in_valid_i && in_ready_i) advance_grid(row_cells_i, first_row_i, last_row_i);
      if (cfg_we_i) width_q = cfg_wdata_i;
      mismatches_o <= mismatches;
      rows_due_o   <= rows_due.size();
    end
  end

endmodule

[bench/life_generation_row_stream_test.sv]
`timescale 1ns / 1ps

// Top of the bench: clock, reset, stimulus and the verdict. All prediction and
// comparison lives in life_row_checker.
module life_generation_row_stream_test;
  import lgr_pkg::*;

  localparam int unsigned MAX_WIDTH    = 64;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          PHASE_ROWS   = 160;
  localparam int          NUM_PHASES   = 8;
  // width per phase, phase 0 in the low bits: 64, 3, 127, 0, 17, 65, 2, 40.
  // Out-of-range values check the clamp; 0 and 127 toggle every register bit.
  localparam logic [NUM_PHASES*CFG_W-1:0] PHASE_WIDTHS =
    {7'd40, 7'd2, 7'd65, 7'd17, 7'd0, 7'd127, 7'd3, 7'd64};

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ROW_W-1:0] row_cells_i;
  logic             first_row_i;
  logic             last_row_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ROW_W-1:0] next_row_cells_o;
  logic             grid_done_o;

  int mismatches;
  int rows_due;
  int cycles = 0;
  int in_idle_pct;     // chance per cycle that the sender holds off
  int out_stall_pct;   // chance per cycle that the receiver drops ready
  int rows_sent;

  life_generation_row_stream #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .row_cells_i     (row_cells_i),
    .first_row_i     (first_row_i),
    .last_row_i      (last_row_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .next_row_cells_o(next_row_cells_o),
    .grid_done_o     (grid_done_o)
  );

  life_row_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .row_cells_i     (row_cells_i),
    .first_row_i     (first_row_i),
    .last_row_i      (last_row_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .next_row_cells_i(next_row_cells_o),
    .grid_done_i     (grid_done_o),
    .mismatches_o    (mismatches),
    .rows_due_o      (rows_due)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Hard stop: far beyond the slowest legal run (up to two results per row, long
  // stalls on both sides), so only a hung handshake gets here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: drops ready at random, at the rate the current phase sets.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // Mixed densities so that births, deaths and survivals all show up.
  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       return a & b;
      1:       return a & b & {$urandom, $urandom};
      2:       return a | b;
      3:       return $urandom_range(1) ? '1 : '0;
      default: return a;
    endcase
  endfunction

  // One in transaction. Valid goes high after the random hold-off and stays
  // up, payload fixed, until the edge at which ready is also high.
  task automatic send_row(input logic [ROW_W-1:0] cells, input logic first_mark,
                          input logic last_mark);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_cells_i <= cells;
    first_row_i <= first_mark;
    last_row_i  <= last_mark;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rows_sent++;
  endtask

  // A grid of random rows; the marks can be left off to get a grid that opens
  // without a first mark or one that never closes.
  task automatic send_grid(input int height, input logic mark_first, input logic close);
    for (int j = 0; j < height; j++) begin
      send_row(random_row(), mark_first && (j == 0), close && (j == height - 1));
    end
  endtask

  // Wait until every due row has come out. A row that releases nothing may
  // still be in the block, so give it a few idle cycles on top.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] w);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int kind;
    int height;
    int goal;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    row_cells_i <= '0;
    first_row_i <= 1'b0;
    last_row_i  <= 1'b0;
    out_stall_pct <= 0;
    in_idle_pct = 0;
    rows_sent   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, reset width of 40 (bits above it must drop) ----
    // single-row grid: passes through once with grid_done
    send_row('1, 1'b1, 1'b1);
    // two-row grid: both are border rows
    send_row('1, 1'b1, 1'b0);
    send_row('0, 1'b0, 1'b1);
    // vertical blinker in column 3 turns horizontal in the middle row
    send_row('0, 1'b1, 1'b0);
    send_row(64'h8, 1'b0, 1'b0);
    send_row(64'h8, 1'b0, 1'b0);
    send_row(64'h8, 1'b0, 1'b0);
    send_row('0, 1'b0, 1'b1);
    // right after a last row: a row with no first mark still opens a grid
    send_row(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0, 1'b1);
    // first mark in the middle of a grid drops the partial grid
    send_row('1, 1'b1, 1'b0);
    send_row(64'hf0f0_f0f0_f0f0_f0f0, 1'b0, 1'b0);
    send_row(64'h0f0f_0f0f_0f0f_0f0f, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b0);
    send_row('0, 1'b0, 1'b1);
    // width raised to the maximum while a grid is open
    send_row('1, 1'b1, 1'b0);
    send_row(64'h1234_5678_9abc_def0, 1'b0, 1'b0);
    write_width(7'd64);
    send_row(64'hdead_beef_cafe_f00d, 1'b0, 1'b0);
    send_row('1, 1'b0, 1'b1);

    // ---- random part: one width per phase, idle pattern cycles per phase ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_width(PHASE_WIDTHS[p*CFG_W +: CFG_W]);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
        1: begin in_idle_pct = 47; out_stall_pct <= 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct <= 47; end
        default: begin in_idle_pct = 20; out_stall_pct <= 20; end
      endcase
      goal = rows_sent + PHASE_ROWS;
      while (rows_sent < goal) begin
        kind   = $urandom_range(99);
        // mostly short grids, now and then a tall one
        height = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(7, 1);
        if (kind < 80)      send_grid(height, 1'b1, 1'b1);  // well formed
        else if (kind < 88) send_grid(height, 1'b0, 1'b1);  // no first mark
        else if (kind < 95) send_grid(height, 1'b1, 1'b0);  // left open
        else send_row(random_row(), 1'(($urandom_range(1))), 1'(($urandom_range(1))));
      end
      // leave a grid open so the next width lands mid-grid
      if (p % 2 == 1) begin
        send_row(random_row(), 1'b1, 1'b0);
        send_row(random_row(), 1'b0, 1'b0);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
src/lgr_pkg.sv
src/lgr_lane.sv
src/lgr_merge.sv
src/life_generation_row_stream.sv
src/lgr_checker.sv
bench/life_row_checker.sv
bench/life_generation_row_stream_test.sv
